// ===== hdl/rde_pkg.sv =====
// Shared types, constants and helpers for the radix digit emitter.
package rde_pkg;

	localparam int RADIX_W = 5;
	localparam int DIGIT_W = 4;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd3;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CONV,
		S_MARK,
		S_SIGN,
		S_DIGIT
	} rde_state_t;

	// Commands from the sequencer to the digit register.
	typedef struct packed {
		logic load;
		logic step;
		logic mark;
		logic pop;
	} rde_ctrl_t;

	// What the digit register reports back.
	typedef struct packed {
		logic [DIGIT_W-1:0] digit;
		logic               at_first;
	} rde_stat_t;

	// Register values below two act as base two, values above sixteen as base sixteen.
	function automatic logic [RADIX_W-1:0] rde_eff_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end else begin
			res = r;
		end
		return res;
	endfunction

endpackage

// ===== hdl/integer_radix_digit_emitter_core.sv =====
// Top level of the radix digit emitter: sequencer, radix register and output register.
//
// Converts one signed WIDTH-bit item into its digits in base 2 to 16, most
// significant first, with a leading minus-sign result for negative items and
// last set on the final result. An item is accepted, its magnitude is shifted
// one bit per cycle into the radix digit register, the top digit is located,
// and then the results (sign plus digits) are loaded into the output register
// whenever it is empty or out_ready is high. The next item is accepted as soon
// as the final result has entered the output register. The radix register
// may be written only while idle.
module integer_radix_digit_emitter_core #(
	parameter int WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic signed [WIDTH-1:0]     value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        is_sign,
	output logic [rde_pkg::DIGIT_W-1:0] digit,
	output logic                        last,
	input  logic                        cfg_we,
	input  logic [rde_pkg::RADIX_W-1:0] cfg_wdata
);
	import rde_pkg::*;

	localparam int CW = $clog2(WIDTH);

	rde_state_t         state_q, state_d;
	rde_ctrl_t          ctrl;
	rde_stat_t          stat;
	logic [RADIX_W-1:0] radix_q;
	logic [RADIX_W-1:0] base_w;
	logic [CW-1:0]      cnt_q;
	logic               neg_q;
	logic [WIDTH-1:0]   value_u;
	logic [WIDTH-1:0]   mag_w;
	logic               slot_free;
	logic               out_load;
	logic               ld_sign;
	logic               ld_last;
	logic [DIGIT_W-1:0] ld_digit;
	logic               ov_q;
	logic               sign_q;
	logic               last_q;
	logic [DIGIT_W-1:0] digit_q;

	assign base_w  = rde_eff_radix(radix_q);
	assign value_u = $unsigned(value);
	// Taken unsigned, so the most negative value yields its true magnitude.
	assign mag_w   = value_u[WIDTH-1] ? (~value_u + WIDTH'(1)) : value_u;

	assign slot_free = !ov_q || out_ready;

	rde_digits #(
		.WIDTH(WIDTH)
	) u_digits (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.mag    (mag_w),
		.base   (base_w),
		.stat   (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				cnt_q <= '0;
				neg_q <= value_u[WIDTH-1];
			end else if (ctrl.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		ctrl     = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		ld_sign  = 1'b0;
		ld_last  = 1'b0;
		ld_digit = '0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.load = 1'b1;
					state_d   = S_CONV;
				end
			end
			S_CONV: begin
				ctrl.step = 1'b1;
				if (cnt_q == CW'(WIDTH - 1)) begin
					state_d = S_MARK;
				end
			end
			S_MARK: begin
				ctrl.mark = 1'b1;
				state_d   = neg_q ? S_SIGN : S_DIGIT;
			end
			S_SIGN: begin
				if (slot_free) begin
					out_load = 1'b1;
					ld_sign  = 1'b1;
					state_d  = S_DIGIT;
				end
			end
			S_DIGIT: begin
				if (slot_free) begin
					out_load = 1'b1;
					ld_digit = stat.digit;
					ld_last  = stat.at_first;
					if (stat.at_first) begin
						state_d = S_IDLE;
					end else begin
						ctrl.pop = 1'b1;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sign_q  <= ld_sign;
			digit_q <= ld_digit;
			last_q  <= ld_last;
		end
	end

	assign out_valid = ov_q;
	assign is_sign   = sign_q;
	assign digit     = digit_q;
	assign last      = last_q;

	a_digit_in_base: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIGIT) |-> ({1'b0, stat.digit} < base_w))
		else $error("digit register holds a digit outside the base");

	a_sign_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_sign) |-> (!last && digit == '0))
		else $error("sign result is flagged last or carries a digit");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_CONV && cnt_q == '0))
		else $error("accepted item did not start conversion");

	a_sign_only_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SIGN) |-> neg_q)
		else $error("sign emitted for a non-negative item");

endmodule

// ===== hdl/rde_digits.sv =====
// Bit-serial binary to radix-N digit register with a read pointer for emission.
module rde_digits #(
	parameter int WIDTH = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rde_pkg::rde_ctrl_t         ctrl,
	input  logic [WIDTH-1:0]           mag,
	input  logic [rde_pkg::RADIX_W-1:0] base,
	output rde_pkg::rde_stat_t         stat
);
	import rde_pkg::*;

	localparam int NDIG = WIDTH;
	localparam int LW   = $clog2(NDIG + 1);
	localparam int PW   = $clog2(NDIG);

	logic [WIDTH-1:0]   mag_q;
	logic [DIGIT_W-1:0] dig_q  [NDIG];
	logic [DIGIT_W-1:0] dig_nx [NDIG];
	logic [NDIG-1:0]    gen;
	logic [NDIG-1:0]    prop;
	logic [NDIG:0]      carry;
	logic [LW-1:0]      len_q;
	logic [PW-1:0]      ptr_q;

	// Each step doubles the digit string and adds the next magnitude bit.
	// A digit carries out when twice its value reaches the base, or when it
	// sits one below and a carry arrives from the digit beneath.
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			gen[i]  = ({dig_q[i], 1'b0} >= base);
			prop[i] = ({dig_q[i], 1'b1} == base);
		end
	end

	always_comb begin
		carry[0] = mag_q[WIDTH-1];
		for (int i = 0; i < NDIG; i++) begin
			carry[i+1] = gen[i] | (prop[i] & carry[i]);
		end
	end

	always_comb begin
		logic [RADIX_W-1:0] sum;
		sum = '0;
		for (int i = 0; i < NDIG; i++) begin
			sum = {dig_q[i], carry[i]};
			dig_nx[i] = carry[i+1] ? DIGIT_W'(sum - base) : sum[DIGIT_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mag_q <= mag;
			for (int i = 0; i < NDIG; i++) begin
				dig_q[i] <= '0;
			end
		end else if (ctrl.step) begin
			mag_q <= {mag_q[WIDTH-2:0], 1'b0};
			for (int i = 0; i < NDIG; i++) begin
				dig_q[i] <= dig_nx[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			ptr_q <= '0;
		end else begin
			if (ctrl.load) begin
				len_q <= '0;
			end else if (ctrl.step && carry[len_q]) begin
				len_q <= len_q + 1'b1;
			end
			// A zero magnitude still shows one digit, the cleared digit zero.
			if (ctrl.mark) begin
				ptr_q <= (len_q == '0) ? '0 : PW'(len_q - 1'b1);
			end else if (ctrl.pop) begin
				ptr_q <= ptr_q - 1'b1;
			end
		end
	end

	assign stat.digit    = dig_q[ptr_q];
	assign stat.at_first = (ptr_q == '0);

endmodule

// ===== bench/tb_integer_radix_digit_emitter_core.sv =====
// Testbench for the radix digit emitter core: directed and random items checked against a predictor.
module tb_integer_radix_digit_emitter_core;
	import rde_pkg::*;

	localparam int W           = 32;
	localparam int CYCLE_LIMIT = 1500000;
	localparam int PHASE_ITEMS = 40;
	localparam int NUM_PHASES  = 12;

	typedef struct packed {
		logic               is_sign;
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} digit_res_t;

	// Holds the digit sequence each accepted item should produce and checks results in order.
	class digit_scoreboard;
		digit_res_t expected_q[$];
		int         errors;

		function new();
			errors = 0;
		endfunction

		function void note_item(logic [W-1:0] v, logic [RADIX_W-1:0] radix_reg);
			int unsigned        base;
			logic [W-1:0]       mag;
			logic [DIGIT_W-1:0] digs[$];
			digit_res_t         r;
			if (radix_reg < RADIX_MIN) begin
				base = RADIX_MIN;
			end else if (radix_reg > RADIX_MAX) begin
				base = RADIX_MAX;
			end else begin
				base = radix_reg;
			end
			// The magnitude is unsigned, so the most negative value keeps its top bit.
			mag = v[W-1] ? (~v + 1'b1) : v;
			if (mag == '0) begin
				r.is_sign = 1'b0;
				r.digit   = '0;
				r.last    = 1'b1;
				expected_q.push_back(r);
				return;
			end
			while (mag != '0) begin
				digs.push_front(DIGIT_W'(mag % base));
				mag = mag / base;
			end
			if (v[W-1]) begin
				r.is_sign = 1'b1;
				r.digit   = '0;
				r.last    = 1'b0;
				expected_q.push_back(r);
			end
			foreach (digs[i]) begin
				r.is_sign = 1'b0;
				r.digit   = digs[i];
				r.last    = (i == digs.size() - 1);
				expected_q.push_back(r);
			end
		endfunction

		function void check_result(logic s, logic [DIGIT_W-1:0] d, logic l);
			digit_res_t e;
			if (expected_q.size() == 0) begin
				$error("unexpected result: is_sign %0b digit %0h last %0b", s, d, l);
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (s !== e.is_sign) begin
				$error("is_sign mismatch: expected %0b, got %0b", e.is_sign, s);
				errors++;
			end
			if (d !== e.digit) begin
				$error("digit mismatch: expected %0h, got %0h", e.digit, d);
				errors++;
			end
			if (l !== e.last) begin
				$error("last mismatch: expected %0b, got %0b", e.last, l);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      in_valid  = 1'b0;
	logic                      in_ready;
	logic signed [W-1:0]       value     = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic                      is_sign;
	logic [DIGIT_W-1:0]        digit;
	logic                      last;
	logic                      cfg_we    = 1'b0;
	logic [RADIX_W-1:0]        cfg_wdata = '0;

	digit_scoreboard    sb = new();
	logic [RADIX_W-1:0] radix_shadow = RADIX_RESET;
	bit                 tx_lazy = 1'b0;
	bit                 rx_lazy = 1'b0;
	int                 rx_hold_cycles = 0;
	int unsigned        cycles = 0;

	integer_radix_digit_emitter_core #(
		.WIDTH(W)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.is_sign  (is_sign),
		.digit    (digit),
		.last     (last),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("integer_radix_digit_emitter_core test failed");
			$finish;
		end
	end

	// Samples handshakes with the values that stood before the edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			radix_shadow = RADIX_RESET;
		end else begin
			if (cfg_we) begin
				radix_shadow = cfg_wdata;
			end
			if (in_valid && in_ready) begin
				sb.note_item(value, radix_shadow);
			end
			if (out_valid && out_ready) begin
				sb.check_result(is_sign, digit, last);
			end
		end
	end

	// Result side: random stalls per result, plus one long hold-off when asked for.
	initial begin
		int gap;
		int h;
		while (!arst_n) @(posedge clk);
		forever begin
			if (rx_hold_cycles > 0) begin
				h = rx_hold_cycles;
				rx_hold_cycles = 0;
				out_ready <= 1'b0;
				repeat (h) @(posedge clk);
			end
			gap = rx_lazy ? $urandom_range(0, 14) : 0;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!out_valid);
		end
	end

	task automatic send_item(input logic [W-1:0] v);
		int gap;
		gap = tx_lazy ? $urandom_range(0, 14) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	// Stops offering items and waits until every predicted digit has come out.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] r);
		cfg_we    <= 1'b1;
		cfg_wdata <= r;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [W-1:0] pick_value(input logic [RADIX_W-1:0] r);
		logic [63:0]  p;
		logic [W-1:0] v;
		int unsigned  b;
		int           k;
		b = (r < 2) ? 2 : ((r > 16) ? 16 : r);
		case ($urandom_range(0, 5))
			0: begin
				v = $urandom;
			end
			1: begin
				v = $urandom_range(0, 300);
			end
			2: begin
				// Powers of the base and one below them hit digit count boundaries.
				p = 64'd1;
				k = $urandom_range(0, 31);
				repeat (k) begin
					if (p * b <= 64'hFFFF_FFFF) begin
						p = p * b;
					end
				end
				v = p[W-1:0] - $urandom_range(0, 1);
			end
			3: begin
				case ($urandom_range(0, 3))
					0: v = '0;
					1: v = {1'b0, {(W-1){1'b1}}};
					2: v = {1'b1, {(W-1){1'b0}}};
					default: v = '1;
				endcase
			end
			default: begin
				v = $urandom >> $urandom_range(0, W - 1);
			end
		endcase
		if ($urandom_range(0, 1)) begin
			v = -v;
		end
		return v;
	endfunction

	initial begin
		logic [W-1:0]       directed[$];
		logic [RADIX_W-1:0] plan[$];
		logic [RADIX_W-1:0] r;
		int                 ph;
		int                 n;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed items at the reset base of three.
		directed = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0002,
			32'h0000_0003, 32'h0000_0008, 32'h0000_0009, 32'h0000_0050,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'hFFFF_FFFD,
			32'hFFFF_FFF7, 32'h5555_5555, 32'hAAAA_AAAA};
		tx_lazy = 1'b1;
		rx_lazy = 1'b1;
		foreach (directed[i]) begin
			send_item(directed[i]);
		end
		drain();

		// Register values outside two to sixteen are clamped by the block.
		plan = '{5'd0, 5'd2, 5'd16, 5'd31, 5'd1, 5'd17, 5'd10, 5'd5, 5'd9, 5'd15};
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			r = (ph < plan.size()) ? plan[ph] : RADIX_W'($urandom_range(0, 31));
			write_radix(r);
			tx_lazy = ($urandom_range(0, 3) != 0);
			rx_lazy = ($urandom_range(0, 3) != 0);
			if (ph == 3) begin
				// Keep the sender busy while results back up behind a long stall.
				tx_lazy = 1'b0;
				rx_hold_cycles = 400;
			end
			for (n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 5 && n == 20) begin
					drain();
				end
				if ($urandom_range(0, 15) == 0) begin
					tx_lazy = ~tx_lazy;
				end
				if ($urandom_range(0, 15) == 0) begin
					rx_lazy = ~rx_lazy;
				end
				send_item(pick_value(r));
			end
			drain();
		end

		repeat (60) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("integer_radix_digit_emitter_core test passed");
		end else begin
			$display("integer_radix_digit_emitter_core test failed");
		end
		$finish;
	end

endmodule
